// ----- sv/mhra_pkg.sv -----
// ---------------------------------------------------------------------------
// mhra_pkg
// Shared constants and types for the multi-pool range allocator.
// ---------------------------------------------------------------------------
package mhra_pkg;

    localparam int MaxPools     = 8;
    localparam int SlotsPerPool = 1024;
    localparam int MaxRanges    = 16;

    localparam int PoolW  = $clog2(MaxPools);
    localparam int RangeW = $clog2(MaxRanges);
    localparam int EntW   = PoolW + RangeW;
    localparam int BoundW = $clog2(SlotsPerPool) + 1;
    localparam int TotalW = $clog2(MaxRanges + 1);
    localparam int OpenW  = $clog2(MaxPools + 1);
    localparam int Depth  = MaxPools * MaxRanges;

    localparam int StrideW = 7;
    localparam logic [StrideW-1:0] StrideReset = 7'd32;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_POOL = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD     = 2'd3
    } status_t;

    // One range list entry: [first, limit)
    typedef struct packed {
        logic [BoundW-1:0] first;
        logic [BoundW-1:0] limit;
    } range_t;

    // Memory access request from the controller
    typedef struct packed {
        logic              rd_en;
        logic [EntW-1:0]   rd_addr;
        logic              wr_en;
        logic [EntW-1:0]   wr_addr;
        range_t            wr_data;
    } mem_req_t;

endpackage

// ----- sv/multi_heap_range_free_list_allocator.sv -----
// ---------------------------------------------------------------------------
// multi_heap_range_free_list_allocator
// Range free-list slot allocator over several pools.
// ---------------------------------------------------------------------------
// Busy stays high from an accepted request until its result strobes. Range
// lists sit in one single-port-read RAM, and the list walk reads one entry at
// a time. An allocate reads the head range and takes its first slot; when the
// head range is used up, each later range is read and written one place down.
// A free reads and checks each range in turn, then appends a one-slot range
// (or reports the list full) if no neighbour is found; a request turned away
// (no pool left, or a pool that is not open) goes straight to the offset
// multiply. Busy falls in the cycle after the strobe. Pool counts live in
// flops, so picking a pool needs no memory read. After reset, pool 0 entry 0
// is written in the init state (busy high for one cycle).
// The result is on the outputs for one cycle with done high; it cannot stall.
module multi_heap_range_free_list_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [2:0]  pool_index,
    input  logic [9:0]  slot_index,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  granted_pool,
    output logic [9:0]  granted_slot,
    output logic [15:0] byte_offset
);

    localparam int PW = mhra_pkg::PoolW;
    localparam int RW = mhra_pkg::RangeW;
    localparam int BW = mhra_pkg::BoundW;
    localparam int TW = mhra_pkg::TotalW;
    localparam int OW = mhra_pkg::OpenW;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_ARD, S_AEVAL, S_SHRD, S_SHWR,
        S_FRD, S_FEVAL, S_MUL, S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [6:0]         stride_reg;
    logic [OW-1:0]      open_reg, open_next;
    logic [TW-1:0]      total_reg [mhra_pkg::MaxPools];
    logic [TW-1:0]      tot_wr_val;
    logic               tot_wr;
    logic [PW-1:0]      pool_reg, pool_next;
    logic [RW-1:0]      idx_reg, idx_next;
    logic [BW-1:0]      slot_reg, slot_next;
    logic [1:0]         stat_reg, stat_next;
    logic [15:0]        off_reg, off_next;
    logic               done_next;
    mhra_pkg::mem_req_t req;
    mhra_pkg::range_t   rd;

    mhra_range_ram u_ram (
        .clk     (clk),
        .req     (req),
        .rd_data (rd)
    );

    // Lowest open pool with a nonempty list
    logic           found;
    logic [PW-1:0]  found_pool;
    always_comb
    begin
        found      = 1'b0;
        found_pool = '0;
        for (int p = mhra_pkg::MaxPools - 1; p >= 0; p--)
        begin
            if ((OW'(p) < open_reg) && (total_reg[p] != '0))
            begin
                found      = 1'b1;
                found_pool = PW'(p);
            end
        end
    end

    logic [TW-1:0] cur_total;
    assign cur_total = total_reg[pool_reg];
    assign cfg_ready = (state_reg == S_IDLE) && !start;
    assign busy      = (state_reg != S_IDLE);

    // Control sequencer
    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        pool_next  = pool_reg;
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        stat_next  = stat_reg;
        off_next   = off_reg;
        done_next  = 1'b0;
        tot_wr     = 1'b0;
        tot_wr_val = '0;
        req        = '0;
        unique case (state_reg)
            S_INIT:
            begin
                req.wr_en         = 1'b1;
                req.wr_addr       = '0;
                req.wr_data.first = '0;
                req.wr_data.limit = BW'(mhra_pkg::SlotsPerPool);
                state_next        = S_IDLE;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    idx_next = '0;
                    if (!action)
                    begin
                        if (found)
                        begin
                            pool_next  = found_pool;
                            state_next = S_ARD;
                        end
                        else if (open_reg >= OW'(mhra_pkg::MaxPools))
                        begin
                            stat_next  = mhra_pkg::ST_NO_POOL;
                            pool_next  = '0;
                            slot_next  = '0;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            // open next pool with one full range
                            pool_next         = PW'(open_reg);
                            open_next         = open_reg + 1'b1;
                            req.wr_en         = 1'b1;
                            req.wr_addr       = {PW'(open_reg), RW'(0)};
                            req.wr_data.first = '0;
                            req.wr_data.limit = BW'(mhra_pkg::SlotsPerPool);
                            tot_wr            = 1'b1;
                            tot_wr_val        = TW'(1);
                            state_next        = S_ARD;
                        end
                    end
                    else
                    begin
                        pool_next = pool_index;
                        slot_next = BW'(slot_index);
                        if ({1'b0, pool_index} >= OW'(open_reg))
                        begin
                            stat_next  = mhra_pkg::ST_BAD;
                            state_next = S_MUL;
                        end
                        else
                        begin
                            state_next = S_FRD;
                        end
                    end
                end
            end
            S_ARD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = {pool_reg, RW'(0)};
                state_next  = S_AEVAL;
            end
            S_AEVAL:
            begin
                slot_next = rd.first;
                stat_next = mhra_pkg::ST_OK;
                if (rd.first + 1'b1 >= rd.limit)
                begin
                    tot_wr     = 1'b1;
                    tot_wr_val = cur_total - 1'b1;
                    if (cur_total > TW'(1))
                    begin
                        idx_next   = RW'(1);
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
                else
                begin
                    req.wr_en         = 1'b1;
                    req.wr_addr       = {pool_reg, RW'(0)};
                    req.wr_data.first = rd.first + 1'b1;
                    req.wr_data.limit = rd.limit;
                    state_next        = S_MUL;
                end
            end
            S_SHRD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = {pool_reg, idx_reg};
                state_next  = S_SHWR;
            end
            S_SHWR:
            begin
                // move entry idx down one place; total already decremented
                req.wr_en   = 1'b1;
                req.wr_addr = {pool_reg, idx_reg - 1'b1};
                req.wr_data = rd;
                if (TW'(idx_reg) >= cur_total)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SHRD;
                end
            end
            S_FRD:
            begin
                if (TW'(idx_reg) >= cur_total || cur_total == '0)
                begin
                    if (cur_total >= TW'(mhra_pkg::MaxRanges))
                    begin
                        stat_next = mhra_pkg::ST_FULL;
                    end
                    else
                    begin
                        stat_next         = mhra_pkg::ST_OK;
                        req.wr_en         = 1'b1;
                        req.wr_addr       = {pool_reg, RW'(cur_total)};
                        req.wr_data.first = slot_reg;
                        req.wr_data.limit = slot_reg + 1'b1;
                        tot_wr            = 1'b1;
                        tot_wr_val        = cur_total + 1'b1;
                    end
                    state_next = S_MUL;
                end
                else
                begin
                    req.rd_en   = 1'b1;
                    req.rd_addr = {pool_reg, idx_reg};
                    state_next  = S_FEVAL;
                end
            end
            S_FEVAL:
            begin
                stat_next = mhra_pkg::ST_OK;
                if (slot_reg + 1'b1 == rd.first)
                begin
                    req.wr_en         = 1'b1;
                    req.wr_addr       = {pool_reg, idx_reg};
                    req.wr_data.first = slot_reg;
                    req.wr_data.limit = rd.limit;
                    state_next        = S_MUL;
                end
                else if (slot_reg == rd.limit)
                begin
                    req.wr_en         = 1'b1;
                    req.wr_addr       = {pool_reg, idx_reg};
                    req.wr_data.first = rd.first;
                    req.wr_data.limit = slot_reg + 1'b1;
                    state_next        = S_MUL;
                end
                else if (TW'(idx_reg) + 1'b1 >= cur_total)
                begin
                    // last entry scanned: go append (or report full)
                    idx_next   = '0;
                    state_next = S_FRD;
                    if (cur_total >= TW'(mhra_pkg::MaxRanges))
                    begin
                        stat_next  = mhra_pkg::ST_FULL;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        req.wr_en         = 1'b1;
                        req.wr_addr       = {pool_reg, RW'(cur_total)};
                        req.wr_data.first = slot_reg;
                        req.wr_data.limit = slot_reg + 1'b1;
                        tot_wr            = 1'b1;
                        tot_wr_val        = cur_total + 1'b1;
                        state_next        = S_MUL;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_FRD;
                end
            end
            S_MUL:
            begin
                // both operands widened first so the product wraps at 16 bits
                off_next   = 16'(slot_reg[9:0]) * 16'(stride_reg);
                done_next  = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, counts and registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            stride_reg <= mhra_pkg::StrideReset;
            open_reg   <= OW'(1);
            done       <= 1'b0;
            for (int p = 0; p < mhra_pkg::MaxPools; p++)
            begin
                total_reg[p] <= (p == 0) ? TW'(1) : '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            open_reg  <= open_next;
            done      <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                stride_reg <= cfg_data;
            end
            if (tot_wr)
            begin
                total_reg[pool_next] <= tot_wr_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pool_reg <= pool_next;
        idx_reg  <= idx_next;
        slot_reg <= slot_next;
        stat_reg <= stat_next;
        off_reg  <= off_next;
    end

    assign status       = stat_reg;
    assign granted_pool = pool_reg;
    assign granted_slot = slot_reg[9:0];
    assign byte_offset  = off_reg;

`ifndef ASSERT_OFF
    a_done_only_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_OUT))
        else $error("result strobe outside output state");
    a_open_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg >= OW'(1)) && (open_reg <= OW'(mhra_pkg::MaxPools)))
        else $error("open pool count out of range");
    a_open_mono: assert property (@(posedge clk) disable iff (!rst_n)
        open_reg >= $past(open_reg))
        else $error("open pool count decreased");
    a_no_pool_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == mhra_pkg::ST_NO_POOL) |->
        (open_reg == OW'(mhra_pkg::MaxPools)))
        else $error("no-pool reported with pools left");
`endif

endmodule

// ----- sv/mhra_range_ram.sv -----
// ---------------------------------------------------------------------------
// mhra_range_ram
// Range list storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mhra_range_ram (
    input  logic                 clk,
    input  mhra_pkg::mem_req_t   req,
    output mhra_pkg::range_t     rd_data
);

    mhra_pkg::range_t mem [mhra_pkg::Depth];

    // Contents undefined until written; the controller never reads unwritten
    // entries because each list is bounded by its range count.
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ----- bench/multi_heap_range_free_list_allocator_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_heap_range_free_list_allocator_tb
// Self-checking bench for the pooled range allocator: a local model of the
// pool range lists predicts every result, which is compared field by field
// as each done strobe arrives. Directed cases, then random request mixes
// under several idle patterns and descriptor stride settings.
// ---------------------------------------------------------------------------
module multi_heap_range_free_list_allocator_tb;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        mhra_pkg::status_t status;
        logic [2:0]        pool;
        logic [9:0]        slot;
        logic [15:0]       offset;
    } grant_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [2:0]  pool_index;
    logic [9:0]  slot_index;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [2:0]  granted_pool;
    logic [9:0]  granted_slot;
    logic [15:0] byte_offset;

    // model state
    logic [6:0]  stride_q;
    int unsigned pools_open;
    int unsigned rng_first [mhra_pkg::MaxPools][mhra_pkg::MaxRanges];
    int unsigned rng_limit [mhra_pkg::MaxPools][mhra_pkg::MaxRanges];
    int unsigned rng_count [mhra_pkg::MaxPools];

    grant_t      grant_q [$];
    int          mismatches;
    int          send_idle_pct;
    // granted slots we may free back, tagged with their pool
    logic [12:0] held_q [$];

    multi_heap_range_free_list_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .pool_index  (pool_index),
        .slot_index  (slot_index),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .done        (done),
        .status      (status),
        .granted_pool(granted_pool),
        .granted_slot(granted_slot),
        .byte_offset (byte_offset)
    );

    always #1 clk = ~clk;

    function automatic grant_t make_grant(mhra_pkg::status_t st, int unsigned p,
                                          int unsigned s);
        grant_t g;
        g.status = st;
        g.pool   = p[2:0];
        g.slot   = s[9:0];
        g.offset = 16'((s * stride_q) & 16'hFFFF);
        return g;
    endfunction

    function automatic void reset_pools();
        foreach (rng_first[p, i])
        begin
            rng_first[p][i] = 0;
            rng_limit[p][i] = 0;
        end
        foreach (rng_count[p])
            rng_count[p] = 0;
        pools_open      = 1;
        rng_limit[0][0] = mhra_pkg::SlotsPerPool;
        rng_count[0]    = 1;
        stride_q        = mhra_pkg::StrideReset;
    endfunction

    // predict an allocate and update the lists
    function automatic grant_t predict_alloc();
        int unsigned p;
        int unsigned s;
        int unsigned n;
        bit          hit;
        hit = 0;
        for (p = 0; p < pools_open; p++)
        begin
            if (rng_count[p] != 0)
            begin
                hit = 1;
                break;
            end
        end
        if (!hit)
        begin
            if (pools_open >= mhra_pkg::MaxPools)
                return make_grant(mhra_pkg::ST_NO_POOL, 0, 0);
            p = pools_open;
            rng_first[p][0] = 0;
            rng_limit[p][0] = mhra_pkg::SlotsPerPool;
            rng_count[p]    = 1;
            pools_open++;
        end
        s = rng_first[p][0];
        rng_first[p][0] = s + 1;
        if (rng_first[p][0] >= rng_limit[p][0])
        begin
            n = rng_count[p];
            for (int i = 0; i + 1 < n; i++)
            begin
                rng_first[p][i] = rng_first[p][i+1];
                rng_limit[p][i] = rng_limit[p][i+1];
            end
            rng_first[p][n-1] = 0;
            rng_limit[p][n-1] = 0;
            rng_count[p]      = n - 1;
        end
        return make_grant(mhra_pkg::ST_OK, p, s);
    endfunction

    // predict a free and update the lists
    function automatic grant_t predict_free(int unsigned p, int unsigned s);
        int unsigned n;
        if (p >= pools_open || s >= mhra_pkg::SlotsPerPool)
            return make_grant(mhra_pkg::ST_BAD, p, s);
        n = rng_count[p];
        for (int i = 0; i < n; i++)
        begin
            if (s + 1 == rng_first[p][i])
            begin
                rng_first[p][i] = s;
                return make_grant(mhra_pkg::ST_OK, p, s);
            end
            if (s == rng_limit[p][i])
            begin
                rng_limit[p][i] = s + 1;
                return make_grant(mhra_pkg::ST_OK, p, s);
            end
        end
        if (n >= mhra_pkg::MaxRanges)
            return make_grant(mhra_pkg::ST_FULL, p, s);
        rng_first[p][n] = s;
        rng_limit[p][n] = s + 1;
        rng_count[p]    = n + 1;
        return make_grant(mhra_pkg::ST_OK, p, s);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("%0t: mismatch %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // result checker
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && done)
        begin
            if (grant_q.size() == 0)
                report_mismatch("unexpected result, status", status, -1);
            else
            begin
                g = grant_q.pop_front();
                if (status != g.status)       report_mismatch("status", status, g.status);
                if (granted_pool != g.pool)   report_mismatch("pool", granted_pool, g.pool);
                if (granted_slot != g.slot)   report_mismatch("slot", granted_slot, g.slot);
                if (byte_offset != g.offset)  report_mismatch("offset", byte_offset, g.offset);
            end
        end
    end

    // send one request; predicts at acceptance
    task automatic send_request(logic act, logic [2:0] p, logic [9:0] s);
        grant_t g;
        while ($urandom_range(99) < send_idle_pct)
            @(posedge clk);
        start      <= 1'b1;
        action     <= act;
        pool_index <= p;
        slot_index <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        start <= 1'b0;
        if (act == ACT_ALLOC)
        begin
            g = predict_alloc();
            if (g.status == mhra_pkg::ST_OK)
                held_q.push_back({g.pool, g.slot});
        end
        else
            g = predict_free(p, s);
        grant_q.push_back(g);
        // block stays busy past this edge, so no request slot is lost
        @(posedge clk);
    endtask

    task automatic drain();
        while (grant_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_stride(logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        stride_q  = v;
        cfg_valid <= 1'b0;
    endtask

    // free a previously granted slot, picked at random
    task automatic free_held();
        int k;
        logic [12:0] e;
        k = $urandom_range(held_q.size() - 1);
        e = held_q[k];
        held_q.delete(k);
        send_request(ACT_FREE, e[12:10], e[9:0]);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        send_request(ACT_ALLOC, 3'd7, 10'h3FF);
        send_request(ACT_ALLOC, 3'd0, 10'd0);
        send_request(ACT_FREE, 3'd0, 10'd1);      // extends first side
        send_request(ACT_FREE, 3'd0, 10'd0);      // extends first side
        send_request(ACT_FREE, 3'd7, 10'd5);      // pool not open
        send_request(ACT_FREE, 3'd0, 10'h3FF);    // appended one-slot range
        send_request(ACT_FREE, 3'd0, 10'h3FF);    // double free, unseen
        send_request(ACT_ALLOC, 3'd0, 10'd0);
        write_stride(7'd0);
        send_request(ACT_ALLOC, 3'd0, 10'd0);
        write_stride(7'h7F);
        send_request(ACT_FREE, 3'd0, 10'd600);
        write_stride(7'd64);
        send_request(ACT_FREE, 3'd0, 10'd900);
    endtask

    // fill a list to its limit with isolated slots, then overflow it
    task automatic test_list_full();
        for (int i = 0; i < mhra_pkg::MaxRanges + 2; i++)
            send_request(ACT_FREE, 3'd0, 10'(20 + 3 * i));
    endtask

    task automatic test_random(int count, int idle_pct);
        int r;
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_request(ACT_ALLOC, 3'($urandom), 10'($urandom));
            else if (r < 85 && held_q.size() != 0)
                free_held();
            else
                send_request(ACT_FREE, 3'($urandom_range(pools_open)), 10'($urandom));
        end
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        action     = 1'b0;
        pool_index = '0;
        slot_index = '0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        mismatches = 0;
        send_idle_pct = 0;
        reset_pools();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_list_full();
        test_random(300, 0);
        write_stride(7'd1);
        test_random(300, 68);
        drain();                 // sender holds until everything is back
        write_stride(7'd13);
        test_random(300, 0);
        write_stride(7'd32);
        test_random(250, 28);
        test_random(170, 0);
        drain();

        if (mismatches == 0)
            $display("multi_heap_range_free_list_allocator_tb: PASS");
        else
            $display("multi_heap_range_free_list_allocator_tb: FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("multi_heap_range_free_list_allocator_tb: FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/mhra_pkg.sv
sv/mhra_range_ram.sv
sv/multi_heap_range_free_list_allocator.sv
bench/multi_heap_range_free_list_allocator_tb.sv
